[hw/rtl/group_hash_find_or_insert_core_assert.svh]
// Assertion macros shared by the group hash core checker.
`ifndef GROUP_HASH_FIND_OR_INSERT_CORE_ASSERT_SVH
`define GROUP_HASH_FIND_OR_INSERT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define GHFI_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("group hash core: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define GHFI_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("group hash core: next-cycle check failed");

`endif

[hw/rtl/ghfi_pkg.sv]
// Shared constants and types of the group hash find-or-insert core.
package ghfi_pkg;

    // Table geometry
    localparam int SLOTS      = 1024;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int CAP_LG_MAX = $clog2(SLOTS + 1) - 1;
    localparam int KEY_WIDTH  = 64;
    localparam int HASH_W     = 64;
    localparam int TAG_W      = HASH_W - 1;
    localparam int KEY_IN_W   = 64;

    // Configuration registers
    localparam int CAP_LG_W   = 4;
    localparam int MAX_ENT_W  = 11;
    localparam int COUNT_W    = 11;
    localparam logic [CAP_LG_W-1:0]  CAP_LG_RESET  = 4'd10;
    localparam logic [MAX_ENT_W-1:0] MAX_ENT_RESET = 11'd768;
    localparam logic [COUNT_W-1:0]   COUNT_MAX     = 11'd2047;

    // Register indexes
    localparam logic REG_CAPACITY    = 1'b0;
    localparam logic REG_MAX_ENTRIES = 1'b1;

    // Result status codes
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STAT_MATCHED   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_CREATED   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

    // Operation codes
    localparam logic OP_FIND_OR_CREATE = 1'b0;
    localparam logic OP_FIND_ONLY      = 1'b1;

    // One table entry: key, occupancy flag and low hash bits
    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic                 occ;
        logic [TAG_W-1:0]     tag;
    } entry_t;

    // Write request from the probe sequencer to the table
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        entry_t            entry;
    } wr_req_t;

endpackage

[hw/rtl/group_hash_find_or_insert_core.sv]
// Top level of the group hash find-or-insert core: APB config, stream ports, probe sequencer.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata {group_key, hash}, tuser operation
//  m_*       out  m_tvalid/m_tready  tdata slot, tuser status
//  apb       in   psel/penable       capacity_log2 at 0x0, max_entries at 0x4
//
//  An item probes P slots, one table read per probe.
//  The slot table is a single-port-read memory; only one item is in flight.
//  After reset a clearing pass empties all 1024 slots of the table; s_tready stays low.
//  A finished result waits in a hold state while the output register is occupied.
module group_hash_find_or_insert_core (
    input  logic         aclk,
    input  logic         aresetn,
    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] hash, [127:64] group_key
    input  logic         s_tuser,   // [0] operation
    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // [9:0] slot, [15:10] zero
    output logic [1:0]   m_tuser,   // [1:0] status
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int SW = ghfi_pkg::SLOT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_HOLD  = 2'd2;

    logic [1:0]                           state_reg, state_next;
    logic                                 create_reg;
    logic [ghfi_pkg::HASH_W-1:0]          hash_reg;
    logic [ghfi_pkg::KEY_WIDTH-1:0]       key_reg;
    logic [SW-1:0]                        start_reg;
    logic [SW-1:0]                        pos_reg, pos_next;
    logic [ghfi_pkg::COUNT_W-1:0]         count_reg, count_next;
    logic [ghfi_pkg::CAP_LG_W-1:0]        cap_lg_reg;
    logic [ghfi_pkg::MAX_ENT_W-1:0]       max_ent_reg;
    logic                                 m_valid_reg, m_valid_next;
    logic [SW-1:0]                        m_slot_reg, m_slot_next;
    logic [ghfi_pkg::STATUS_W-1:0]        m_status_reg, m_status_next;
    logic [SW-1:0]                        res_slot_reg, res_slot_next;
    logic [ghfi_pkg::STATUS_W-1:0]        res_status_reg, res_status_next;

    logic [ghfi_pkg::CAP_LG_W-1:0]        eff_lg;
    logic [SW-1:0]                        mask;
    logic [SW-1:0]                        pos_inc;
    logic [SW-1:0]                        rd_addr;
    ghfi_pkg::entry_t                     rd_data;
    ghfi_pkg::wr_req_t                    wr;
    logic                                 tbl_busy;
    logic                                 s_accept;
    logic                                 out_free;
    logic                                 cfg_wr;
    logic                                 hit;
    logic                                 done;
    logic [SW-1:0]                        done_slot;
    logic [ghfi_pkg::STATUS_W-1:0]        done_status;

    ghfi_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr),
        .busy    (tbl_busy)
    );

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_lg_reg  <= ghfi_pkg::CAP_LG_RESET;
            max_ent_reg <= ghfi_pkg::MAX_ENT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == ghfi_pkg::REG_CAPACITY) begin
                cap_lg_reg <= pwdata[ghfi_pkg::CAP_LG_W-1:0];
            end else begin
                max_ent_reg <= pwdata[ghfi_pkg::MAX_ENT_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == ghfi_pkg::REG_MAX_ENTRIES) begin
            prdata = {{(32 - ghfi_pkg::MAX_ENT_W){1'b0}}, max_ent_reg};
        end else begin
            prdata = {{(32 - ghfi_pkg::CAP_LG_W){1'b0}}, cap_lg_reg};
        end
    end

    // Clamp capacity and build the slot mask
    always_comb begin
        if (cap_lg_reg == '0) begin
            eff_lg = ghfi_pkg::CAP_LG_W'(1);
        end else if (cap_lg_reg > ghfi_pkg::CAP_LG_W'(ghfi_pkg::CAP_LG_MAX)) begin
            eff_lg = ghfi_pkg::CAP_LG_W'(ghfi_pkg::CAP_LG_MAX);
        end else begin
            eff_lg = cap_lg_reg;
        end
        for (int i = 0; i < SW; i++) begin
            mask[i] = (5'(i) < {1'b0, eff_lg});
        end
    end

    // Probe compare on the entry read last cycle
    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE) && !tbl_busy;
    assign out_free = !m_valid_reg || m_tready;
    assign pos_inc  = (pos_reg + 1'b1) & mask;
    assign hit      = (rd_data.tag == hash_reg[ghfi_pkg::TAG_W-1:0]) && (rd_data.key == key_reg);

    always_comb begin
        done        = 1'b0;
        done_slot   = pos_reg;
        done_status = ghfi_pkg::STAT_MATCHED;
        wr.en       = 1'b0;
        wr.addr     = pos_reg;
        wr.entry.key = key_reg;
        wr.entry.occ = 1'b1;
        wr.entry.tag = hash_reg[ghfi_pkg::TAG_W-1:0];
        count_next  = count_reg;
        if (state_reg == ST_PROBE) begin
            if (!rd_data.occ) begin
                done = 1'b1;
                if (!create_reg) begin
                    done_status = ghfi_pkg::STAT_NOT_FOUND;
                end else if (count_reg >= max_ent_reg) begin
                    done_status = ghfi_pkg::STAT_FULL;
                end else begin
                    done_status = ghfi_pkg::STAT_CREATED;
                    wr.en       = 1'b1;
                    if (count_reg != ghfi_pkg::COUNT_MAX) begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end else if (hit) begin
                done = 1'b1;
            end else if (pos_inc == start_reg) begin
                // every slot in use probed without a match
                done        = 1'b1;
                done_slot   = start_reg;
                done_status = create_reg ? ghfi_pkg::STAT_FULL : ghfi_pkg::STAT_NOT_FOUND;
            end
        end
    end

    // Read address: start slot on accept, next slot while probing
    always_comb begin
        case (state_reg)
            ST_IDLE:  rd_addr = s_tdata[SW-1:0] & mask;
            ST_PROBE: rd_addr = pos_inc;
            default:  rd_addr = pos_reg;
        endcase
    end

    // Sequencer and output register
    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        m_slot_next     = m_slot_reg;
        m_status_next   = m_status_reg;
        m_valid_next    = m_tready ? 1'b0 : m_valid_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    pos_next   = s_tdata[SW-1:0] & mask;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (done) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_slot_next   = done_slot;
                        m_status_next = done_status;
                        state_next    = ST_IDLE;
                    end else begin
                        res_slot_next   = done_slot;
                        res_status_next = done_status;
                        state_next      = ST_HOLD;
                    end
                end else begin
                    pos_next = pos_inc;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_slot_next   = res_slot_reg;
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
    end

    // Hold item fields and probe position
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            create_reg <= (s_tuser == ghfi_pkg::OP_FIND_OR_CREATE);
            hash_reg   <= s_tdata[ghfi_pkg::HASH_W-1:0];
            key_reg    <= s_tdata[ghfi_pkg::HASH_W +: ghfi_pkg::KEY_WIDTH];
            start_reg  <= s_tdata[SW-1:0] & mask;
        end
        pos_reg        <= pos_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        m_slot_reg     <= m_slot_next;
        m_status_reg   <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16 - SW){1'b0}}, m_slot_reg};
    assign m_tuser  = m_status_reg;

endmodule

[hw/rtl/ghfi_table.sv]
// Slot table memory with a clearing sweep after reset.
module ghfi_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ghfi_pkg::SLOT_W-1:0]   rd_addr,
    output ghfi_pkg::entry_t              rd_data,
    input  ghfi_pkg::wr_req_t             wr,
    output logic                          busy
);

    ghfi_pkg::entry_t                mem [ghfi_pkg::SLOTS];
    ghfi_pkg::entry_t                rd_data_reg;
    logic                            clr_busy_reg;
    logic [ghfi_pkg::SLOT_W-1:0]     clr_idx_reg;

    // Sweep every entry to empty after reset, one per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == ghfi_pkg::SLOT_W'(ghfi_pkg::SLOTS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Write port: sweep has priority, sequencer is held off meanwhile
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_idx_reg] <= '0;
        end else if (wr.en) begin
            mem[wr.addr] <= wr.entry;
        end
    end

    // Read port, registered output
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

[hw/rtl/ghfi_checker.sv]
// Port-level checker for the group hash core, bound to the top level.
`include "group_hash_find_or_insert_core_assert.svh"

module ghfi_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [15:0]  m_tdata,
    input logic [1:0]   m_tuser
);

    // Stalled result beat holds its payload
    `GHFI_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // One item in flight: no new beat right after one is taken
    `GHFI_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // A result never shows up in the cycle after an input beat
    `GHFI_ASSERT_NXT(a_min_latency, aclk, aresetn, s_tvalid && s_tready && !m_tvalid, !m_tvalid)

    // Slot padding stays zero
    `GHFI_ASSERT_IMP(a_slot_pad, aclk, aresetn, m_tvalid, m_tdata[15:10] == 6'd0)

endmodule

bind group_hash_find_or_insert_core ghfi_checker u_ghfi_checker (.*);
